### sv/slcfd_pkg.sv
// Package with the shared types, constants and CRC function of the frame deframer.
package slcfd_pkg;

    localparam logic [7:0]  SYNC_FIRST  = 8'h5A;
    localparam logic [7:0]  SYNC_SECOND = 8'hA5;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam logic [15:0] MAX_LEN_RESET    = 16'd8186;
    localparam logic [7:0]  REC_TAG_RESET    = 8'h91;
    localparam logic [7:0]  REC_LEN_RESET    = 8'd76;

    typedef enum logic [1:0] {
        REG_MAX_LEN = 2'd0,
        REG_REC_TAG = 2'd1,
        REG_REC_LEN = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_SYNC2   = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_CRC_LO  = 3'd4,
        PH_CRC_HI  = 3'd5,
        PH_PAYLOAD = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_TOO_LONG = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] max_payload_len;
        logic [7:0]  record_tag;
        logic [7:0]  record_len;
    } cfg_t;

    typedef struct packed {
        logic        has_data;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic        frame_end;
        status_t     frame_status;
        logic [15:0] record_count;
    } result_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte per call.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] CRC_START = crc_byte(16'h0000, SYNC_FIRST);

endpackage

### sv/slcfd_parser.sv
// Frame parser: phase machine, header capture, running CRC and record counting.
module slcfd_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            rx_byte,
    input  slcfd_pkg::cfg_t       cfg,
    output logic                  res_valid,
    output slcfd_pkg::result_t    res
);

    slcfd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] received_crc_reg, received_crc_next;
    logic [15:0] running_crc_reg, running_crc_next;
    logic [15:0] payload_position_reg, payload_position_next;
    logic [7:0]  record_offset_reg, record_offset_next;
    logic [15:0] records_found_reg, records_found_next;
    logic        counting_records_reg, counting_records_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;
    logic [15:0] rcrc_full;
    logic [16:0] pos_inc;
    logic [8:0]  off_inc;
    logic        crc_good_payload;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= slcfd_pkg::PH_HUNT;
            frame_length_reg     <= '0;
            received_crc_reg     <= '0;
            running_crc_reg      <= '0;
            payload_position_reg <= '0;
            record_offset_reg    <= '0;
            records_found_reg    <= '0;
            counting_records_reg <= 1'b1;
        end else if (in_fire) begin
            phase_reg            <= phase_next;
            frame_length_reg     <= frame_length_next;
            received_crc_reg     <= received_crc_next;
            running_crc_reg      <= running_crc_next;
            payload_position_reg <= payload_position_next;
            record_offset_reg    <= record_offset_next;
            records_found_reg    <= records_found_next;
            counting_records_reg <= counting_records_next;
        end
    end

    always_comb begin
        crc_upd          = slcfd_pkg::crc_byte(running_crc_reg, rx_byte);
        len_full         = {rx_byte, frame_length_reg[7:0]};
        rcrc_full        = {rx_byte, received_crc_reg[7:0]};
        pos_inc          = {1'b0, payload_position_reg} + 17'd1;
        off_inc          = {1'b0, record_offset_reg} + 9'd1;
        crc_good_payload = (crc_upd == received_crc_reg);

        phase_next            = phase_reg;
        frame_length_next     = frame_length_reg;
        received_crc_next     = received_crc_reg;
        running_crc_next      = running_crc_reg;
        payload_position_next = payload_position_reg;
        record_offset_next    = record_offset_reg;
        records_found_next    = records_found_reg;
        counting_records_next = counting_records_reg;

        res_valid        = 1'b0;
        res.has_data     = 1'b0;
        res.payload_byte = '0;
        res.byte_index   = '0;
        res.frame_end    = 1'b0;
        res.frame_status = slcfd_pkg::ST_GOOD;
        res.record_count = '0;

        unique case (phase_reg)
            slcfd_pkg::PH_HUNT: begin
                if (rx_byte == slcfd_pkg::SYNC_FIRST) begin
                    running_crc_next = slcfd_pkg::CRC_START;
                    phase_next       = slcfd_pkg::PH_SYNC2;
                end
            end
            slcfd_pkg::PH_SYNC2: begin
                if (rx_byte == slcfd_pkg::SYNC_SECOND) begin
                    running_crc_next = crc_upd;
                    phase_next       = slcfd_pkg::PH_LEN_LO;
                end else if (rx_byte == slcfd_pkg::SYNC_FIRST) begin
                    running_crc_next = slcfd_pkg::CRC_START;
                end else begin
                    phase_next = slcfd_pkg::PH_HUNT;
                end
            end
            slcfd_pkg::PH_LEN_LO: begin
                frame_length_next = {8'h00, rx_byte};
                running_crc_next  = crc_upd;
                phase_next        = slcfd_pkg::PH_LEN_HI;
            end
            slcfd_pkg::PH_LEN_HI: begin
                frame_length_next = len_full;
                running_crc_next  = crc_upd;
                if (len_full > cfg.max_payload_len) begin
                    phase_next       = slcfd_pkg::PH_HUNT;
                    res_valid        = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = slcfd_pkg::ST_TOO_LONG;
                end else begin
                    phase_next = slcfd_pkg::PH_CRC_LO;
                end
            end
            slcfd_pkg::PH_CRC_LO: begin
                received_crc_next = {8'h00, rx_byte};
                phase_next        = slcfd_pkg::PH_CRC_HI;
            end
            slcfd_pkg::PH_CRC_HI: begin
                received_crc_next     = rcrc_full;
                payload_position_next = '0;
                record_offset_next    = '0;
                records_found_next    = '0;
                counting_records_next = (cfg.record_len != 8'd0);
                if (frame_length_reg == 16'd0) begin
                    phase_next       = slcfd_pkg::PH_HUNT;
                    res_valid        = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = (running_crc_reg == rcrc_full) ?
                                       slcfd_pkg::ST_GOOD : slcfd_pkg::ST_CRC_BAD;
                end else begin
                    phase_next = slcfd_pkg::PH_PAYLOAD;
                end
            end
            slcfd_pkg::PH_PAYLOAD: begin
                running_crc_next = crc_upd;
                if (counting_records_reg) begin
                    if (record_offset_reg == 8'd0 && rx_byte != cfg.record_tag) begin
                        counting_records_next = 1'b0;
                    end else if (off_inc >= {1'b0, cfg.record_len}) begin
                        records_found_next = records_found_reg + 16'd1;
                        record_offset_next = '0;
                    end else begin
                        record_offset_next = off_inc[7:0];
                    end
                end
                res_valid        = 1'b1;
                res.has_data     = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_index   = payload_position_reg;
                if (pos_inc >= {1'b0, frame_length_reg}) begin
                    phase_next       = slcfd_pkg::PH_HUNT;
                    res.frame_end    = 1'b1;
                    res.frame_status = crc_good_payload ?
                                       slcfd_pkg::ST_GOOD : slcfd_pkg::ST_CRC_BAD;
                    res.record_count = crc_good_payload ? records_found_next : 16'd0;
                end else begin
                    payload_position_next = pos_inc[15:0];
                end
            end
            default: begin
                phase_next = slcfd_pkg::PH_HUNT;
                if (rx_byte == slcfd_pkg::SYNC_FIRST) begin
                    running_crc_next = slcfd_pkg::CRC_START;
                    phase_next       = slcfd_pkg::PH_SYNC2;
                end
            end
        endcase
    end

endmodule

### sv/sync_length_crc_frame_deframer_top.sv
// Top level of the sync/length/CRC frame deframer with config registers and result register.
// A result is registered and appears on the m_ side in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the input is ready; the per-byte CRC update is a single unrolled stage.
// The input is ready whenever the result register is empty or being taken in the same cycle.
// Reset (aresetn low, synchronous) returns the parser to sync hunting, empties the result
// register and loads the configuration registers with their default values.
module sync_length_crc_frame_deframer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_has_data,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_byte_index,
    output logic        m_frame_end,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_record_count
);

    slcfd_pkg::cfg_t    cfg_reg;
    slcfd_pkg::result_t res;
    slcfd_pkg::result_t out_reg;
    logic               out_valid_reg, out_valid_next;
    logic               res_valid;
    logic               in_fire;

    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_payload_len <= slcfd_pkg::MAX_LEN_RESET;
            cfg_reg.record_tag      <= slcfd_pkg::REC_TAG_RESET;
            cfg_reg.record_len      <= slcfd_pkg::REC_LEN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                slcfd_pkg::REG_MAX_LEN: cfg_reg.max_payload_len <= cfg_data;
                slcfd_pkg::REG_REC_TAG: cfg_reg.record_tag      <= cfg_data[7:0];
                slcfd_pkg::REG_REC_LEN: cfg_reg.record_len      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    slcfd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .rx_byte   (s_rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        if (in_fire && res_valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_has_data     = out_reg.has_data;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_byte_index   = out_reg.byte_index;
    assign m_frame_end    = out_reg.frame_end;
    assign m_frame_status = out_reg.frame_status;
    assign m_record_count = out_reg.record_count;

endmodule

### sv/slcfd_checker.sv
// Port-level checker for the frame deframer and its bind to the top level.
module slcfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_has_data,
    input logic [7:0]  m_payload_byte,
    input logic [15:0] m_byte_index,
    input logic        m_frame_end,
    input logic [1:0]  m_frame_status,
    input logic [15:0] m_record_count
);

    // A result that is not taken stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_byte)
            && $stable(m_byte_index) && $stable(m_frame_end)
            && $stable(m_frame_status) && $stable(m_record_count))
        else $error("result changed while stalled");

    // Every item that is not a frame end carries a payload byte with neutral status.
    a_mid_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_end |-> m_has_data && m_frame_status == slcfd_pkg::ST_GOOD
            && m_record_count == 16'd0)
        else $error("mid-frame item without data or with status");

    // An aborted frame reports no data and no records.
    a_too_long: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status == slcfd_pkg::ST_TOO_LONG |->
            !m_has_data && m_frame_end && m_record_count == 16'd0)
        else $error("length abort with data or records");

    // A bad CRC never reports records.
    a_crc_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status == slcfd_pkg::ST_CRC_BAD |-> m_record_count == 16'd0)
        else $error("records reported for bad frame");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result valid after reset");

endmodule

bind sync_length_crc_frame_deframer_top slcfd_checker u_slcfd_checker (.*);

### sim/sync_length_crc_frame_deframer_top_tb.sv
// Self-checking testbench for the sync/length/CRC frame deframer top level.
`timescale 1ns / 100ps

module sync_length_crc_frame_deframer_top_tb;

    localparam int WATCHDOG_LIMIT = 1000;

    class deframe_tracker;
        localparam logic [15:0] DEF_MAX_LEN = 16'd8186;
        localparam logic [7:0]  DEF_REC_TAG = 8'h91;
        localparam logic [7:0]  DEF_REC_LEN = 8'd76;
        localparam logic [15:0] CRC16_POLY  = 16'h1021;
        localparam int          PRINT_CAP   = 40;

        logic [15:0]          max_len;
        logic [7:0]           rec_tag;
        logic [7:0]           rec_len;
        slcfd_pkg::phase_t    phase;
        logic [15:0]          frame_len;
        logic [15:0]          rx_crc;
        logic [15:0]          crc_acc;
        logic [15:0]          pay_pos;
        logic [15:0]          rec_total;
        logic [7:0]           rec_off;
        bit                   counting;
        slcfd_pkg::result_t   expected_q[$];
        int                   errors;

        function new();
            max_len = DEF_MAX_LEN;
            rec_tag = DEF_REC_TAG;
            rec_len = DEF_REC_LEN;
            phase = slcfd_pkg::PH_HUNT;
            frame_len = '0;
            rx_crc = '0;
            crc_acc = '0;
            pay_pos = '0;
            rec_total = '0;
            rec_off = '0;
            counting = 1'b1;
            errors = 0;
        endfunction

        static function logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
            logic [15:0] acc;
            logic        fb;
            acc = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = acc[15] ^ data[i];
                acc = {acc[14:0], 1'b0};
                if (fb) begin
                    acc = acc ^ CRC16_POLY;
                end
            end
            return acc;
        endfunction

        function void set_register(input slcfd_pkg::cfg_index_t idx, input logic [15:0] value);
            case (idx)
                slcfd_pkg::REG_MAX_LEN: max_len = value;
                slcfd_pkg::REG_REC_TAG: rec_tag = value[7:0];
                slcfd_pkg::REG_REC_LEN: rec_len = value[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void start_sync();
            crc_acc = crc16_step(16'h0000, slcfd_pkg::SYNC_FIRST);
            phase = slcfd_pkg::PH_SYNC2;
        endfunction

        function void note_byte(input logic [7:0] b);
            slcfd_pkg::result_t r;
            r = '0;
            case (phase)
                slcfd_pkg::PH_HUNT: begin
                    if (b == slcfd_pkg::SYNC_FIRST) begin
                        start_sync();
                    end
                end
                slcfd_pkg::PH_SYNC2: begin
                    if (b == slcfd_pkg::SYNC_SECOND) begin
                        crc_acc = crc16_step(crc_acc, b);
                        phase = slcfd_pkg::PH_LEN_LO;
                    end else if (b == slcfd_pkg::SYNC_FIRST) begin
                        start_sync();
                    end else begin
                        phase = slcfd_pkg::PH_HUNT;
                    end
                end
                slcfd_pkg::PH_LEN_LO: begin
                    frame_len = {8'h00, b};
                    crc_acc = crc16_step(crc_acc, b);
                    phase = slcfd_pkg::PH_LEN_HI;
                end
                slcfd_pkg::PH_LEN_HI: begin
                    frame_len[15:8] = b;
                    crc_acc = crc16_step(crc_acc, b);
                    if (frame_len > max_len) begin
                        phase = slcfd_pkg::PH_HUNT;
                        r.frame_end = 1'b1;
                        r.frame_status = slcfd_pkg::ST_TOO_LONG;
                        expected_q.push_back(r);
                    end else begin
                        phase = slcfd_pkg::PH_CRC_LO;
                    end
                end
                slcfd_pkg::PH_CRC_LO: begin
                    rx_crc = {8'h00, b};
                    phase = slcfd_pkg::PH_CRC_HI;
                end
                slcfd_pkg::PH_CRC_HI: begin
                    rx_crc[15:8] = b;
                    pay_pos = '0;
                    rec_off = '0;
                    rec_total = '0;
                    counting = (rec_len != 8'd0);
                    if (frame_len == 16'd0) begin
                        phase = slcfd_pkg::PH_HUNT;
                        r.frame_end = 1'b1;
                        r.frame_status = (crc_acc == rx_crc) ? slcfd_pkg::ST_GOOD
                                                             : slcfd_pkg::ST_CRC_BAD;
                        expected_q.push_back(r);
                    end else begin
                        phase = slcfd_pkg::PH_PAYLOAD;
                    end
                end
                slcfd_pkg::PH_PAYLOAD: begin
                    crc_acc = crc16_step(crc_acc, b);
                    if (counting) begin
                        if (rec_off == 8'd0 && b != rec_tag) begin
                            counting = 1'b0;
                        end else if ({1'b0, rec_off} + 9'd1 >= {1'b0, rec_len}) begin
                            rec_total = rec_total + 16'd1;
                            rec_off = '0;
                        end else begin
                            rec_off = rec_off + 8'd1;
                        end
                    end
                    r.has_data = 1'b1;
                    r.payload_byte = b;
                    r.byte_index = pay_pos;
                    if (pay_pos == frame_len - 16'd1) begin
                        phase = slcfd_pkg::PH_HUNT;
                        r.frame_end = 1'b1;
                        if (crc_acc == rx_crc) begin
                            r.frame_status = slcfd_pkg::ST_GOOD;
                            r.record_count = rec_total;
                        end else begin
                            r.frame_status = slcfd_pkg::ST_CRC_BAD;
                        end
                    end else begin
                        pay_pos = pay_pos + 16'd1;
                    end
                    expected_q.push_back(r);
                end
                default: begin
                    phase = slcfd_pkg::PH_HUNT;
                    if (b == slcfd_pkg::SYNC_FIRST) begin
                        start_sync();
                    end
                end
            endcase
        endfunction

        task report(input string what);
            if (errors < PRINT_CAP) begin
                $display("[%0t] %s", $time, what);
            end
            errors++;
        endtask

        task check_result(input slcfd_pkg::result_t got);
            slcfd_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result: data %0b byte %02h index %0d end %0b",
                                 got.has_data, got.payload_byte, got.byte_index, got.frame_end));
                return;
            end
            want = expected_q.pop_front();
            if (got.has_data !== want.has_data)
                report($sformatf("has_data got %0b want %0b", got.has_data, want.has_data));
            if (got.payload_byte !== want.payload_byte)
                report($sformatf("payload_byte got %02h want %02h",
                                 got.payload_byte, want.payload_byte));
            if (got.byte_index !== want.byte_index)
                report($sformatf("byte_index got %0d want %0d", got.byte_index, want.byte_index));
            if (got.frame_end !== want.frame_end)
                report($sformatf("frame_end got %0b want %0b", got.frame_end, want.frame_end));
            if (got.frame_status !== want.frame_status)
                report($sformatf("frame_status got %0d want %0d",
                                 got.frame_status, want.frame_status));
            if (got.record_count !== want.record_count)
                report($sformatf("record_count got %0d want %0d",
                                 got.record_count, want.record_count));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_has_data;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_byte_index;
    logic        m_frame_end;
    logic [1:0]  m_frame_status;
    logic [15:0] m_record_count;

    deframe_tracker tracker;
    int burst_left;
    int sent_count;
    int idle_cycles;
    int stall_mode;
    int stall_left;
    int stall_tick;

    sync_length_crc_frame_deframer_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_has_data     (m_has_data),
        .m_payload_byte (m_payload_byte),
        .m_byte_index   (m_byte_index),
        .m_frame_end    (m_frame_end),
        .m_frame_status (m_frame_status),
        .m_record_count (m_record_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        slcfd_pkg::result_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                got.has_data = m_has_data;
                got.payload_byte = m_payload_byte;
                got.byte_index = m_byte_index;
                got.frame_end = m_frame_end;
                got.frame_status = slcfd_pkg::status_t'(m_frame_status);
                got.record_count = m_record_count;
                tracker.check_result(got);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_length_crc_frame_deframer_top: mismatch");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (stall_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end else begin
            stall_left--;
        end
        stall_tick++;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= (stall_tick % 16) >= 12;
            default: m_ready <= $urandom_range(0, 1);
        endcase
    end

    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        burst_left--;
        sent_count++;
    endtask

    task automatic write_reg(input slcfd_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        tracker.set_register(idx, value);
    endtask

    task automatic go_quiet();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic settle_parser();
        while (tracker.phase != slcfd_pkg::PH_HUNT) send_byte(8'h00);
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == slcfd_pkg::SYNC_SECOND) begin
            b = 8'h00;
        end
        return b;
    endfunction

    function automatic int pick_len();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            n = $urandom_range(0, 12);
        end else if (r < 97) begin
            n = $urandom_range(13, 48);
        end else begin
            n = $urandom_range(49, 300);
        end
        if (n > int'(tracker.max_len)) begin
            n = int'(tracker.max_len);
        end
        return n;
    endfunction

    function automatic int too_long_len();
        if (tracker.max_len == 16'hFFFF) begin
            return pick_len();
        end
        if ($urandom_range(0, 2) == 0) begin
            return int'(tracker.max_len) + 1;
        end
        return $urandom_range(int'(tracker.max_len) + 1, 65535);
    endfunction

    task automatic send_frame(input int len, input bit corrupt, input bit embed_sync);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [15:0] flen;
        int          n;
        int          rl;
        int          nrec;
        int          pos;
        flen = 16'(len);
        n = (flen > tracker.max_len) ? 0 : len;
        rl = int'(tracker.rec_len);
        nrec = (rl != 0) ? $urandom_range(0, n / rl + 1) : 0;
        for (int i = 0; i < n; i++) begin
            if (rl != 0 && i % rl == 0 && i / rl < nrec) begin
                body.push_back(tracker.rec_tag);
            end else begin
                body.push_back(8'($urandom));
            end
        end
        if (embed_sync && n >= 2) begin
            pos = $urandom_range(0, n - 2);
            body[pos] = slcfd_pkg::SYNC_FIRST;
            body[pos + 1] = slcfd_pkg::SYNC_SECOND;
        end
        crc = deframe_tracker::crc16_step(16'h0000, slcfd_pkg::SYNC_FIRST);
        crc = deframe_tracker::crc16_step(crc, slcfd_pkg::SYNC_SECOND);
        crc = deframe_tracker::crc16_step(crc, flen[7:0]);
        crc = deframe_tracker::crc16_step(crc, flen[15:8]);
        foreach (body[k]) begin
            crc = deframe_tracker::crc16_step(crc, body[k]);
        end
        if (corrupt) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        send_byte(slcfd_pkg::SYNC_FIRST);
        send_byte(slcfd_pkg::SYNC_SECOND);
        send_byte(flen[7:0]);
        send_byte(flen[15:8]);
        if (flen > tracker.max_len) begin
            return;
        end
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[k]) begin
            send_byte(body[k]);
        end
    endtask

    task automatic run_phase(input logic [15:0] max_len, input logic [7:0] tag,
                             input logic [7:0] rlen, input int nbytes);
        int goal;
        int pick;
        settle_parser();
        go_quiet();
        write_reg(slcfd_pkg::REG_MAX_LEN, max_len);
        write_reg(slcfd_pkg::REG_REC_TAG, {8'($urandom), tag});
        write_reg(slcfd_pkg::REG_REC_LEN, {8'($urandom), rlen});
        goal = sent_count + nbytes;
        while (sent_count < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                send_frame(pick_len(), 1'b0, $urandom_range(0, 9) == 0);
            end else if (pick < 74) begin
                send_frame(pick_len(), 1'b1, $urandom_range(0, 3) == 0);
            end else if (pick < 80) begin
                send_frame(too_long_len(), 1'b0, 1'b0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            end else if (pick < 94) begin
                send_byte(slcfd_pkg::SYNC_FIRST);
                send_byte(noise_byte());
            end else begin
                send_byte(slcfd_pkg::SYNC_FIRST);
                send_frame(pick_len(), 1'b0, 1'b0);
            end
            if ($urandom_range(0, 59) == 0) begin
                go_quiet();
            end
        end
    endtask

    initial begin
        tracker = new();
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = slcfd_pkg::REG_MAX_LEN;
        cfg_data = '0;
        s_valid = 1'b0;
        s_rx_byte = '0;
        m_ready = 1'b0;
        burst_left = 0;
        sent_count = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_left = 0;
        stall_tick = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_reg(slcfd_pkg::REG_REC_LEN, 16'd1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(slcfd_pkg::SYNC_FIRST);
        send_byte(8'h00);
        send_byte(slcfd_pkg::SYNC_FIRST);
        send_frame(0, 1'b0, 1'b0);
        send_frame(65535, 1'b0, 1'b0);
        send_frame(2, 1'b0, 1'b0);
        send_frame(0, 1'b1, 1'b0);
        send_frame(1, 1'b1, 1'b0);

        run_phase(16'd8186, 8'h91, 8'd76, 150);
        run_phase(16'd0, 8'($urandom), 8'd1, 100);
        run_phase(16'd40, 8'h00, 8'd1, 150);
        run_phase(16'hFFFF, 8'hFF, 8'd255, 200);
        run_phase(16'd20, 8'($urandom), 8'd3, 150);
        run_phase(16'($urandom_range(0, 60)), 8'($urandom), 8'd0, 150);
        run_phase(16'($urandom_range(0, 100)), 8'($urandom), 8'($urandom_range(1, 8)), 150);
        run_phase(16'($urandom_range(0, 65535)), 8'($urandom), 8'($urandom_range(1, 4)), 150);

        go_quiet();
        repeat (8) @(negedge aclk);
        if (tracker.errors == 0) begin
            $display("sync_length_crc_frame_deframer_top: match");
        end else begin
            $display("sync_length_crc_frame_deframer_top: mismatch");
        end
        $finish;
    end

endmodule
